/* hdl/fltpm_pkg.sv */
// Shared types and constants for the four-level page table mapper.
// Used by fltpm_ctrl, fltpm_datapath and the top level; no dependencies.
package fltpm_pkg;

    localparam int MAX_TABLES_DEF  = 64;
    localparam int ENTRY_IDX_W     = 9;     // 512 entries per table
    localparam int ENTRY_W         = 64;
    localparam int PADDR_W         = 52;
    localparam int VADDR_W         = 48;
    localparam int FRAME_W         = 40;    // address bits 51..12
    localparam int LIMIT_W         = 7;
    localparam int IN_DATA_W       = 184;
    localparam int OUT_DATA_W      = 80;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOMEM   = 2'd2;

    // operation codes
    localparam logic OP_MAP  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] SIZE_BAD = 2'd3;

    // configuration register indexes
    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;

    // entry bits
    localparam int BIT_P  = 0;
    localparam int BIT_PS = 7;
    localparam logic [ENTRY_W-1:0] CMP_MASK = 64'h800F_FFFF_FFFF_F19F;

    // evaluation outcome of one fetched entry
    localparam logic [1:0] EV_FIN   = 2'd0;
    localparam logic [1:0] EV_ALLOC = 2'd1;
    localparam logic [1:0] EV_PTR   = 2'd2;
    localparam logic [1:0] EV_LEAF  = 2'd3;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic rd;
        logic alloc;
        logic ptr;
        logic leaf_wr;
        logic fin;
        logic fail;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] ev;
        logic       ptr_ok;
    } stat_t;

endpackage

/* hdl/four_level_page_table_mapper.sv */
// Four-level page table mapper: ties the sequencer to the datapath.
// Depends on fltpm_pkg, fltpm_ctrl and fltpm_datapath.
//
// Use: one item on the s_axis channel is either a map request (tuser 0) or a
// read of one stored entry (tuser 1). Each item gives exactly one result item
// on m_axis: status, entry data (reads only) and the count of tables in use.
// Items are handled one at a time; s_axis_tready is high only when idle.
// Steps: a read fetches the entry from the table store, evaluates it and holds
// the result. A map fetches and evaluates one entry per level through the single
// memory port, allocates and writes a missing table before moving on, adds a
// pointer step when an existing pointer is converted to a table number, and ends
// early for large pages or errors. s_axis_tready rises again in the cycle after
// the result leaves.
// Reset: the table store is swept to zero, one entry per cycle, with
// s_axis_tready low; configuration writes are taken at any time and should be
// made while idle.
// A stalled m_axis holds the result and blocks the next item.
module four_level_page_table_mapper
#(
    parameter int MAX_TABLES = fltpm_pkg::MAX_TABLES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // phys_addr, virt_addr, page_size_code, attr_bits, not_present,
    // read_table, read_index, zero pad
    input  logic [fltpm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // op
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status, entry_data, tables_used, zero pad
    output logic [fltpm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [fltpm_pkg::PADDR_W-1:0]       cfg_data
);

    fltpm_pkg::cmd_t  cmd;
    fltpm_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    fltpm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fltpm_datapath #(.MAX_TABLES(MAX_TABLES)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_sel   (cfg_index),
        .cfg_value (cfg_data),
        .in_op     (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .out_data  (m_axis_tdata)
    );

endmodule

/* hdl/fltpm_ctrl.sv */
// Sequencer for the page table mapper: clearing pass, walk steps, result hold.
// Depends on fltpm_pkg.
module fltpm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  fltpm_pkg::stat_t    stat,
    output fltpm_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_PTR   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                case (stat.ev)
                    fltpm_pkg::EV_ALLOC:
                    begin
                        cmd.alloc  = 1'b1;
                        state_next = S_READ;
                    end
                    fltpm_pkg::EV_PTR:
                    begin
                        state_next = S_PTR;
                    end
                    fltpm_pkg::EV_LEAF:
                    begin
                        cmd.leaf_wr = 1'b1;
                        cmd.fin     = 1'b1;
                        state_next  = S_DONE;
                    end
                    default:
                    begin
                        cmd.fin    = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_PTR:
            begin
                if (stat.ptr_ok)
                begin
                    cmd.ptr    = 1'b1;
                    state_next = S_READ;
                end
                else
                begin
                    cmd.fin    = 1'b1;
                    cmd.fail   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

/* hdl/fltpm_datapath.sv */
// Datapath of the page table mapper: table store, bump allocator, walk
// registers, entry checks and result registers. Depends on fltpm_pkg.
module fltpm_datapath
#(
    parameter int MAX_TABLES = fltpm_pkg::MAX_TABLES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  fltpm_pkg::cmd_t                     cmd,
    output fltpm_pkg::stat_t                    stat,
    input  logic                                cfg_we,
    input  logic                                cfg_sel,
    input  logic [fltpm_pkg::PADDR_W-1:0]       cfg_value,
    input  logic                                in_op,
    input  logic [fltpm_pkg::IN_DATA_W-1:0]     in_data,
    output logic [fltpm_pkg::OUT_DATA_W-1:0]    out_data
);

    localparam int TW    = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int AW    = TW + fltpm_pkg::ENTRY_IDX_W;
    localparam int DEPTH = MAX_TABLES * (2 ** fltpm_pkg::ENTRY_IDX_W);
    localparam int NW    = $clog2(MAX_TABLES + 1);
    localparam int EW    = fltpm_pkg::ENTRY_W;
    localparam int FW    = fltpm_pkg::FRAME_W;

    logic [EW-1:0] mem [DEPTH];

    // configuration
    logic [FW-1:0]                  base_reg;
    logic [fltpm_pkg::LIMIT_W-1:0]  limit_reg;

    // control state
    logic [NW-1:0] nf_reg;
    logic [AW-1:0] clr_reg;
    logic [1:0]    lvl_reg;
    logic [TW-1:0] tbl_reg;

    // latched request
    logic                           op_reg;
    logic [fltpm_pkg::PADDR_W-1:0]  phys_reg;
    logic [fltpm_pkg::VADDR_W-1:0]  virt_reg;
    logic [1:0]                     size_reg;
    logic [EW-1:0]                  attr_reg;
    logic                           np_reg;
    logic [5:0]                     rtab_reg;
    logic [8:0]                     ridx_reg;

    logic [EW-1:0] rdata_reg;
    logic [1:0]    ost_reg;
    logic [EW-1:0] odata_reg;

    logic [1:0]    leaf_lvl;
    logic [8:0]    lvl_idx;
    logic [AW-1:0] slot;
    logic          read_bad;
    logic          full;
    logic [FW-1:0] ptr_tbl;
    logic [EW-1:0] alloc_entry;
    logic [fltpm_pkg::PADDR_W-1:0] phys_al;
    logic [EW-1:0] leaf_entry;
    logic [1:0]    ev_sel;
    logic [1:0]    ev_status;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [EW-1:0] mem_wdata;

    assign leaf_lvl = 2'd3 - size_reg;

    always_comb
    begin
        case (lvl_reg)
            2'd0:    lvl_idx = virt_reg[47:39];
            2'd1:    lvl_idx = virt_reg[38:30];
            2'd2:    lvl_idx = virt_reg[29:21];
            default: lvl_idx = virt_reg[20:12];
        endcase
    end

    assign slot = (op_reg == fltpm_pkg::OP_READ) ? {TW'(rtab_reg), ridx_reg}
                                                 : {tbl_reg, lvl_idx};
    assign read_bad = (32'(rtab_reg) >= MAX_TABLES);
    assign full = (32'(nf_reg) >= MAX_TABLES) || (32'(nf_reg) >= 32'(limit_reg));

    assign ptr_tbl = rdata_reg[51:12] - base_reg;
    assign alloc_entry = {12'd0, base_reg + FW'(nf_reg), 12'h003};

    always_comb
    begin
        case (size_reg)
            2'd0:    phys_al = {phys_reg[51:12], 12'd0};
            2'd1:    phys_al = {phys_reg[51:21], 21'd0};
            default: phys_al = {phys_reg[51:30], 30'd0};
        endcase
    end

    assign leaf_entry = {12'd0, phys_al} | attr_reg
                      | {56'd0, (size_reg != 2'd0), 6'd0, !np_reg};

    // decide what the fetched entry means
    always_comb
    begin
        ev_sel    = fltpm_pkg::EV_FIN;
        ev_status = fltpm_pkg::ST_OK;
        if (op_reg == fltpm_pkg::OP_READ)
        begin
            ev_status = read_bad ? fltpm_pkg::ST_INVALID : fltpm_pkg::ST_OK;
        end
        else if (size_reg == fltpm_pkg::SIZE_BAD)
        begin
            ev_status = fltpm_pkg::ST_INVALID;
        end
        else if (lvl_reg != leaf_lvl)
        begin
            if (rdata_reg[fltpm_pkg::BIT_P])
            begin
                // PML4 entries are not checked for a large page
                if (lvl_reg != 2'd0 && rdata_reg[fltpm_pkg::BIT_PS])
                    ev_status = fltpm_pkg::ST_INVALID;
                else
                    ev_sel = fltpm_pkg::EV_PTR;
            end
            else if (full)
                ev_status = fltpm_pkg::ST_NOMEM;
            else
                ev_sel = fltpm_pkg::EV_ALLOC;
        end
        else if (rdata_reg[fltpm_pkg::BIT_P])
        begin
            if (leaf_lvl != 2'd3 && !rdata_reg[fltpm_pkg::BIT_PS])
                ev_status = fltpm_pkg::ST_INVALID;
            else if ((rdata_reg & fltpm_pkg::CMP_MASK) != (leaf_entry & fltpm_pkg::CMP_MASK))
                ev_status = fltpm_pkg::ST_INVALID;
        end
        else
        begin
            ev_sel = fltpm_pkg::EV_LEAF;
        end
    end

    assign stat.ev       = ev_sel;
    assign stat.ptr_ok   = (ptr_tbl < FW'(MAX_TABLES));
    assign stat.clr_last = (clr_reg == AW'(DEPTH - 1));

    assign mem_we    = cmd.clr_step | cmd.alloc | cmd.leaf_wr;
    assign mem_addr  = cmd.clr_step ? clr_reg : slot;
    assign mem_wdata = cmd.clr_step ? '0 : (cmd.alloc ? alloc_entry : leaf_entry);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (cmd.rd)
            rdata_reg <= mem[slot];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            limit_reg <= fltpm_pkg::LIMIT_RST;
            nf_reg    <= NW'(1);
            clr_reg   <= '0;
            lvl_reg   <= '0;
            tbl_reg   <= '0;
        end
        else
        begin
            if (cfg_we && cfg_sel == fltpm_pkg::CFG_BASE)
                base_reg <= cfg_value[51:12];
            if (cfg_we && cfg_sel == fltpm_pkg::CFG_LIMIT)
                limit_reg <= cfg_value[fltpm_pkg::LIMIT_W-1:0];
            if (cmd.clr_step)
                clr_reg <= clr_reg + AW'(1);
            if (cmd.load)
            begin
                lvl_reg <= '0;
                tbl_reg <= '0;
            end
            else if (cmd.alloc)
            begin
                lvl_reg <= lvl_reg + 2'd1;
                tbl_reg <= TW'(nf_reg);
                nf_reg  <= nf_reg + NW'(1);
            end
            else if (cmd.ptr)
            begin
                lvl_reg <= lvl_reg + 2'd1;
                tbl_reg <= ptr_tbl[TW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            phys_reg <= in_data[51:0];
            virt_reg <= in_data[99:52];
            size_reg <= in_data[101:100];
            attr_reg <= in_data[165:102];
            np_reg   <= in_data[166];
            rtab_reg <= in_data[172:167];
            ridx_reg <= in_data[181:173];
        end
        if (cmd.fin)
        begin
            ost_reg   <= cmd.fail ? fltpm_pkg::ST_INVALID : ev_status;
            odata_reg <= (op_reg == fltpm_pkg::OP_READ && !read_bad) ? rdata_reg : '0;
        end
    end

    assign out_data = {7'd0, 7'(nf_reg), odata_reg, ost_reg};

endmodule

/* hdl/fltpm_checker.sv */
// Port-level checks for the page table mapper, bound to the top level.
// Depends on fltpm_pkg.
module fltpm_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [fltpm_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    // one item at a time: no intake while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("result repeated");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item taken while busy");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind four_level_page_table_mapper fltpm_checker u_fltpm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/four_level_page_table_mapper_test.sv */
// Self-checking testbench for four_level_page_table_mapper: random and directed
// map/read items against a shadow page table kept in the testbench.
// Depends on fltpm_pkg and the four_level_page_table_mapper RTL.
`timescale 1ns / 1ps

module four_level_page_table_mapper_test;

    localparam int  LIMIT_CYCLES = 800000;
    localparam int  PHASE_ITEMS  = 500;
    localparam logic [63:0] FRAME = 64'h000F_FFFF_FFFF_F000;

    typedef struct packed {
        logic        op;
        logic [51:0] phys;
        logic [47:0] virt;
        logic [1:0]  size;
        logic [63:0] attr;
        logic        np;
        logic [5:0]  rtab;
        logic [8:0]  ridx;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] entry;
        logic [6:0]  used;
    } rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [fltpm_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = fltpm_pkg::OP_MAP;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [fltpm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = fltpm_pkg::CFG_BASE;
    logic [fltpm_pkg::PADDR_W-1:0] cfg_data = '0;

    four_level_page_table_mapper u_dut (.*);

    always #5 clk = ~clk;

    // shadow of the page table store and allocator
    logic [63:0] pt_shadow [int];
    logic [6:0]  next_tbl = 7'd1;
    logic [51:0] base_reg = '0;
    logic [6:0]  limit_reg = fltpm_pkg::LIMIT_RST;

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];
    req_t map_history [$];
    logic [47:0] vpool [8];

    int src_idle = 0;
    int snk_stall = 0;
    int n_issued = 0;
    int n_taken = 0;
    int errors = 0;
    int cycles = 0;

    function automatic logic [63:0] shadow_rd(int slot);
        return pt_shadow.exists(slot) ? pt_shadow[slot] : 64'd0;
    endfunction

    function automatic logic [1:0] map_page(req_t r);
        logic [63:0] psz, phys, virt, flags, pres, e, want, lim, off;
        int tbl, leaf, idx, slot;
        int sh [4];
        sh = '{39, 30, 21, 12};
        if (r.size == fltpm_pkg::SIZE_BAD)
            return fltpm_pkg::ST_INVALID;
        psz = (r.size == 2'd0) ? 64'h1000 : (r.size == 2'd1) ? 64'h20_0000 : 64'h4000_0000;
        phys = {12'd0, r.phys} & ~(psz - 1);
        virt = {16'd0, r.virt} & ~(psz - 1);
        flags = r.attr | ((r.size != 2'd0) ? 64'h80 : 64'h0);
        pres = r.np ? 64'd0 : 64'd1;
        leaf = 3 - r.size;
        tbl = 0;
        for (int lvl = 0; lvl < leaf; lvl++)
        begin
            idx = int'((virt >> sh[lvl]) & 64'h1FF);
            slot = tbl * 512 + idx;
            e = shadow_rd(slot);
            if (e[0])
            begin
                if (lvl >= 1 && e[7])
                    return fltpm_pkg::ST_INVALID;
            end
            else
            begin
                lim = (limit_reg > 7'd64) ? 64'd64 : {57'd0, limit_reg};
                if ({57'd0, next_tbl} >= lim)
                    return fltpm_pkg::ST_NOMEM;
                e = ((({12'd0, base_reg} & FRAME) + ({57'd0, next_tbl} << 12)) & FRAME)
                    | 64'h3;
                next_tbl = next_tbl + 7'd1;
                pt_shadow[slot] = e;
            end
            off = ((e & FRAME) - ({12'd0, base_reg} & FRAME)) & 64'h000F_FFFF_FFFF_FFFF;
            if ((off >> 12) >= 64)
                return fltpm_pkg::ST_INVALID;
            tbl = int'(off >> 12);
        end
        idx = int'((virt >> sh[leaf]) & 64'h1FF);
        slot = tbl * 512 + idx;
        e = shadow_rd(slot);
        want = (phys & FRAME) | flags | pres;
        if (e[0])
        begin
            if (leaf < 3 && !e[7])
                return fltpm_pkg::ST_INVALID;
            return ((e & fltpm_pkg::CMP_MASK) == (want & fltpm_pkg::CMP_MASK))
                   ? fltpm_pkg::ST_OK : fltpm_pkg::ST_INVALID;
        end
        pt_shadow[slot] = phys | flags | pres;
        return fltpm_pkg::ST_OK;
    endfunction

    task automatic predict_rsp(req_t r);
        rsp_t x;
        x.entry = '0;
        if (r.op == fltpm_pkg::OP_READ)
        begin
            x.status = fltpm_pkg::ST_OK;
            x.entry = shadow_rd(int'(r.rtab) * 512 + int'(r.ridx));
        end
        else
            x.status = map_page(r);
        x.used = next_tbl;
        expected_rsps.push_back(x);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    function automatic logic [fltpm_pkg::IN_DATA_W-1:0] pack_req(req_t r);
        return {2'b00, r.ridx, r.rtab, r.np, r.attr, r.size, r.virt, r.phys};
    endfunction

    function automatic req_t unpack_req(logic [fltpm_pkg::IN_DATA_W-1:0] d, logic op);
        req_t r;
        r.op = op;
        r.phys = d[51:0];
        r.virt = d[99:52];
        r.size = d[101:100];
        r.attr = d[165:102];
        r.np = d[166];
        r.rtab = d[172:167];
        r.ridx = d[181:173];
        return r;
    endfunction

    // acceptance, prediction and result check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_rsp(unpack_req(s_axis_tdata, s_axis_tuser));
                n_taken <= n_taken + 1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected item", m_axis_tdata[63:0], 64'd0);
                else
                begin
                    rsp_t w;
                    w = expected_rsps.pop_front();
                    if (m_axis_tdata[1:0] !== w.status)
                        report_mismatch("status", m_axis_tdata[1:0], w.status);
                    if (m_axis_tdata[65:2] !== w.entry)
                        report_mismatch("entry_data", m_axis_tdata[65:2], w.entry);
                    if (m_axis_tdata[72:66] !== w.used)
                        report_mismatch("tables_used", m_axis_tdata[72:66], w.used);
                end
            end
        end
    end

    // stream driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= snk_stall);
            if (!s_axis_tvalid || n_taken == n_issued)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= src_idle)
                begin
                    req_t r;
                    r = pending_reqs.pop_front();
                    s_axis_tdata <= pack_req(r);
                    s_axis_tuser <= r.op;
                    s_axis_tvalid <= 1'b1;
                    n_issued <= n_issued + 1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic write_reg(logic idx, logic [51:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == fltpm_pkg::CFG_BASE)
            base_reg = val;
        else
            limit_reg = val[6:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic req_t map_req(logic [47:0] v, logic [51:0] p, logic [1:0] sz,
                                     logic [63:0] a, logic np);
        req_t r;
        r = '{op: fltpm_pkg::OP_MAP, phys: p, virt: v, size: sz, attr: a, np: np,
              rtab: $urandom, ridx: $urandom};
        return r;
    endfunction

    function automatic req_t read_req(logic [5:0] t, logic [8:0] i);
        req_t r;
        r = '{op: fltpm_pkg::OP_READ, phys: {$urandom, $urandom},
              virt: {$urandom, $urandom}, size: $urandom, attr: {$urandom, $urandom},
              np: $urandom, rtab: t, ridx: i};
        return r;
    endfunction

    function automatic req_t random_req;
        req_t r;
        int k, pick;
        logic [47:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            k = $urandom_range(0, 3);
            v = vpool[$urandom_range(0, 7)];
            return read_req((pick < 15) ? 6'($urandom_range(0, next_tbl)) : 6'($urandom),
                            (k == 0) ? v[47:39] : (k == 1) ? v[38:30] :
                            (k == 2) ? v[29:21] : 9'($urandom));
        end
        if (pick < 33 && map_history.size() != 0)
        begin
            r = map_history[$urandom_range(0, map_history.size() - 1)];
            if ($urandom_range(0, 3) == 0)
                r.attr[$urandom_range(0, 63)] ^= 1'b1;
            return r;
        end
        v = (pick < 40) ? 48'({$urandom, $urandom})
                        : {vpool[$urandom_range(0, 7)][47:21], 21'($urandom)};
        k = $urandom_range(0, 99);
        r = map_req(v, {$urandom, $urandom}, (k < 60) ? 2'd0 : (k < 80) ? 2'd1 :
                    (k < 95) ? 2'd2 : fltpm_pkg::SIZE_BAD, {$urandom, $urandom},
                    $urandom_range(0, 7) == 0);
        map_history.push_back(r);
        if (map_history.size() > 32)
            void'(map_history.pop_front());
        return r;
    endfunction

    initial
    begin
        int idle_src [4];
        int idle_snk [4];
        logic [51:0] bases [4];
        logic [6:0]  limits [4];
        idle_src = '{0, 47, 0, 20};
        idle_snk = '{0, 0, 47, 20};
        bases = '{52'd0, 52'hF_FFFF_FFFF_FFFF, 52'd0, 52'($urandom) << 12};
        limits = '{7'd64, 7'd127, 7'd0, 7'd1};
        foreach (vpool[i])
            vpool[i] = 48'({$urandom, $urandom});
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: leaf, re-map, clashes, bad size, large pages, extremes
        pending_reqs.push_back(map_req(48'd0, 52'hF_FFFF_FFFF_FFFF, 2'd0, '1, 1'b0));
        pending_reqs.push_back(read_req(6'd3, 9'd0));
        pending_reqs.push_back(map_req(48'd0, 52'hF_FFFF_FFFF_FFFF, 2'd0, '1, 1'b0));
        pending_reqs.push_back(map_req(48'd0, 52'h1000, 2'd0, '1, 1'b0));
        pending_reqs.push_back(map_req(48'd0, 52'd0, 2'd1, 64'd0, 1'b0));
        pending_reqs.push_back(map_req(48'hFFFF_FFFF_FFFF, 52'd0, 2'd2, 64'd0, 1'b0));
        pending_reqs.push_back(map_req(48'hFFFF_FFFF_F000, 52'd0, 2'd0, 64'd0, 1'b0));
        pending_reqs.push_back(map_req(48'hFFFF_FFFF_FFFF, 52'd0, 2'd1, 64'd0, 1'b0));
        pending_reqs.push_back(map_req(48'h0000_4000_0000, 52'h12_3456, 2'd1, 64'h6, 1'b1));
        pending_reqs.push_back(map_req(48'h0000_4000_0000, 52'h12_3456, 2'd1, 64'h6, 1'b0));
        pending_reqs.push_back(map_req(48'h0000_4020_0000, 52'd0, 2'd0, 64'd0, 1'b0));
        pending_reqs.push_back(map_req(48'h1234_5678_9000, 52'd0, fltpm_pkg::SIZE_BAD,
                                       '1, 1'b0));
        pending_reqs.push_back(read_req(6'd0, 9'd0));
        pending_reqs.push_back(read_req(6'd0, 9'd511));
        pending_reqs.push_back(read_req(6'd63, 9'd511));
        pending_reqs.push_back(read_req(6'd2, 9'd0));

        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            write_reg(fltpm_pkg::CFG_BASE, bases[ph]);
            write_reg(fltpm_pkg::CFG_LIMIT, limits[ph]);
            src_idle = idle_src[ph];
            snk_stall = idle_snk[ph];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // sender holds off until the block has emptied
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    drain();
                pending_reqs.push_back(random_req());
                if (pending_reqs.size() > 8)
                    while (pending_reqs.size() > 4)
                        @(posedge clk);
            end
        end
        drain();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
hdl/fltpm_pkg.sv
hdl/fltpm_ctrl.sv
hdl/fltpm_datapath.sv
hdl/four_level_page_table_mapper.sv
hdl/fltpm_checker.sv
tb/sv/four_level_page_table_mapper_test.sv
